FILE: hw/rtl/rgbycc_pkg.sv
`timescale 1ns / 1ps

package rgbycc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COMP_W    = 8;
    localparam int OPND_W    = COMP_W + 1;
    localparam int COEF_W    = FRAC_BITS + 2;
    localparam int PROD_W    = COEF_W + OPND_W;
    localparam int ACC_W     = FRAC_BITS + 12;
    localparam int LANES     = 3;

    typedef logic [1:0] t_mode;

    localparam t_mode MODE_BGR2YCC  = 2'd0;
    localparam t_mode MODE_YCC2BGR  = 2'd1;
    localparam t_mode MODE_BGR2GRAY = 2'd2;
    localparam t_mode MODE_BYPASS   = 2'd3;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [OPND_W-1:0] t_opnd;
    typedef logic signed [PROD_W-1:0] t_prod;

    function automatic t_coef fx_coef(input longint unsigned micro);
        longint unsigned scaled;
        scaled = ((micro << FRAC_BITS) + 64'd500000) / 64'd1000000;
        return COEF_W'(scaled);
    endfunction

    localparam t_coef K_ONE  = t_coef'(64'd1 << FRAC_BITS);
    localparam t_coef K_ZERO = '0;
    localparam t_coef K_YR   = fx_coef(64'd299000);
    localparam t_coef K_YG   = fx_coef(64'd587000);
    localparam t_coef K_YB   = fx_coef(64'd114000);
    localparam t_coef K_CB_R = fx_coef(64'd168736);
    localparam t_coef K_CB_G = fx_coef(64'd331264);
    localparam t_coef K_HALF = fx_coef(64'd500000);
    localparam t_coef K_CR_G = fx_coef(64'd418688);
    localparam t_coef K_CR_B = fx_coef(64'd81312);
    localparam t_coef K_R_CR = fx_coef(64'd1402000);
    localparam t_coef K_G_CB = fx_coef(64'd344136);
    localparam t_coef K_G_CR = fx_coef(64'd714136);
    localparam t_coef K_B_CB = fx_coef(64'd1772000);

    localparam t_acc OFF_ROUND  = t_acc'(64'd1 << (FRAC_BITS - 1));
    localparam t_acc OFF_CHROMA = t_acc'((64'd128 << FRAC_BITS) + (64'd1 << (FRAC_BITS - 1)));

    typedef struct packed {
        t_coef k0;
        t_coef k1;
        t_coef k2;
        t_acc  off;
    } t_lane_coef;

    typedef t_lane_coef [LANES-1:0] t_coef_set;

    typedef struct packed {
        logic adv2;
        logic adv3;
        logic adv4;
    } t_pipe_ctl;

    function automatic t_coef_set coef_set(input t_mode mode);
        t_coef_set s;
        t_lane_coef y;
        y = '{k0: K_YB, k1: K_YG, k2: K_YR, off: OFF_ROUND};
        case (mode)
            MODE_BGR2YCC: begin
                s[0] = y;
                s[1] = '{k0: K_HALF, k1: -K_CB_G, k2: -K_CB_R, off: OFF_CHROMA};
                s[2] = '{k0: -K_CR_B, k1: -K_CR_G, k2: K_HALF, off: OFF_CHROMA};
            end
            MODE_YCC2BGR: begin
                s[0] = '{k0: K_ONE, k1: K_B_CB, k2: K_ZERO, off: OFF_ROUND};
                s[1] = '{k0: K_ONE, k1: -K_G_CB, k2: -K_G_CR, off: OFF_ROUND};
                s[2] = '{k0: K_ONE, k1: K_ZERO, k2: K_R_CR, off: OFF_ROUND};
            end
            MODE_BGR2GRAY: begin
                s[0] = y;
                s[1] = y;
                s[2] = y;
            end
            default: begin
                s[0] = '{k0: K_ONE, k1: K_ZERO, k2: K_ZERO, off: OFF_ROUND};
                s[1] = '{k0: K_ZERO, k1: K_ONE, k2: K_ZERO, off: OFF_ROUND};
                s[2] = '{k0: K_ZERO, k1: K_ZERO, k2: K_ONE, off: OFF_ROUND};
            end
        endcase
        return s;
    endfunction

endpackage

FILE: hw/rtl/rgb_ycbcr_color_converter.sv
`timescale 1ns / 1ps

// Full-range JFIF color converter, one pixel per clock. Mode 0 turns B,G,R into
// Y,Cb,Cr, mode 1 turns Y,Cb,Cr into B,G,R, mode 2 puts the luma of B,G,R on all
// three outputs and mode 3 passes the pixel through. Coefficients carry 16
// fraction bits; every result is rounded half up and clamped to 0..255. A pixel
// passes the operand register, the multipliers, the adder and the round and
// clamp register in turn; the pipeline takes a new word every cycle while the
// output takes one, and when the output is held off only the full stages stall,
// so an empty stage still fills. Write the mode only while no pixel is in flight.

module rgb_ycbcr_color_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // comp_a [7:0], comp_b [15:8], comp_c [23:16]
    input  logic        s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // res_a [7:0], res_b [15:8], res_c [23:16]
    output logic        m_axis_tlast    // frame_end_out
);
    import rgbycc_pkg::*;

    t_mode     r_mode;
    t_opnd     r_x0, r_x1, r_x2;
    t_opnd     n_x1, n_x2;
    t_mode     r_mode1;
    logic      r_v1, r_v2, r_v3, r_v4;
    logic      r_last1, r_last2, r_last3, r_last4;
    logic      adv1;
    t_pipe_ctl ctl;
    t_coef_set coefs;
    logic [7:0] res [LANES];

    assign ctl.adv4 = !r_v4 || m_axis_tready;
    assign ctl.adv3 = !r_v3 || ctl.adv4;
    assign ctl.adv2 = !r_v2 || ctl.adv3;
    assign adv1     = !r_v1 || ctl.adv2;

    assign s_axis_tready = adv1;

    always_comb begin
        if (r_mode == MODE_YCC2BGR) begin
            n_x1 = t_opnd'({1'b0, s_axis_tdata[15:8]}) - t_opnd'(128);
            n_x2 = t_opnd'({1'b0, s_axis_tdata[23:16]}) - t_opnd'(128);
        end else begin
            n_x1 = t_opnd'({1'b0, s_axis_tdata[15:8]});
            n_x2 = t_opnd'({1'b0, s_axis_tdata[23:16]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BGR2YCC;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (adv1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (ctl.adv2) begin
                r_v2 <= r_v1;
            end
            if (ctl.adv3) begin
                r_v3 <= r_v2;
            end
            if (ctl.adv4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_x0    <= t_opnd'({1'b0, s_axis_tdata[7:0]});
            r_x1    <= n_x1;
            r_x2    <= n_x2;
            r_mode1 <= r_mode;
            r_last1 <= s_axis_tlast;
        end
        if (ctl.adv2) begin
            r_last2 <= r_last1;
        end
        if (ctl.adv3) begin
            r_last3 <= r_last2;
        end
        if (ctl.adv4) begin
            r_last4 <= r_last3;
        end
    end

    assign coefs = coef_set(r_mode1);

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        rgbycc_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_x0   (r_x0),
            .i_x1   (r_x1),
            .i_x2   (r_x2),
            .i_coef (coefs[g]),
            .o_res  (res[g])
        );
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {res[2], res[1], res[0]};
    assign m_axis_tlast  = r_last4;

endmodule

FILE: hw/rtl/rgbycc_lane.sv
`timescale 1ns / 1ps

module rgbycc_lane (
    input  logic                    i_clk,
    input  rgbycc_pkg::t_pipe_ctl   i_ctl,
    input  rgbycc_pkg::t_opnd       i_x0,
    input  rgbycc_pkg::t_opnd       i_x1,
    input  rgbycc_pkg::t_opnd       i_x2,
    input  rgbycc_pkg::t_lane_coef  i_coef,
    output logic [7:0]              o_res
);
    import rgbycc_pkg::*;

    t_prod n_p0, n_p1, n_p2;
    t_prod r_p0, r_p1, r_p2;
    t_acc  r_off;
    t_acc  n_acc, r_acc;
    logic [7:0] n_res, r_res;

    assign n_p0 = i_x0 * i_coef.k0;
    assign n_p1 = i_x1 * i_coef.k1;
    assign n_p2 = i_x2 * i_coef.k2;

    assign n_acc = ACC_W'(r_p0) + ACC_W'(r_p1) + ACC_W'(r_p2) + r_off;

    always_comb begin
        if (r_acc[ACC_W-1]) begin
            n_res = 8'd0;
        end else if (|r_acc[ACC_W-2:FRAC_BITS+8]) begin
            n_res = 8'd255;
        end else begin
            n_res = r_acc[FRAC_BITS+7:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv2) begin
            r_p0  <= n_p0;
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_off <= i_coef.off;
        end
        if (i_ctl.adv3) begin
            r_acc <= n_acc;
        end
        if (i_ctl.adv4) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

FILE: tb/sv/rgb_ycbcr_color_converter_tb.sv
`timescale 1ns / 1ps

module rgb_ycbcr_color_converter_tb;

    import rgbycc_pkg::*;

    localparam int  FB         = FRAC_BITS;
    localparam int  PIPE_DEPTH = 8;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic       eof;
    } t_pixel;

    function automatic longint fx(input longint micro);
        return ((micro << FB) + 64'd500000) / 64'd1000000;
    endfunction

    localparam longint CF_YR   = fx(299000);
    localparam longint CF_YG   = fx(587000);
    localparam longint CF_YB   = fx(114000);
    localparam longint CF_CB_R = fx(168736);
    localparam longint CF_CB_G = fx(331264);
    localparam longint CF_HALF = fx(500000);
    localparam longint CF_CR_G = fx(418688);
    localparam longint CF_CR_B = fx(81312);
    localparam longint CF_R_CR = fx(1402000);
    localparam longint CF_G_CB = fx(344136);
    localparam longint CF_G_CR = fx(714136);
    localparam longint CF_B_CB = fx(1772000);
    localparam longint CHROMA  = longint'(128) << FB;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // comp_a [7:0], comp_b [15:8], comp_c [23:16]
    logic        s_axis_tlast;   // frame_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // res_a [7:0], res_b [15:8], res_c [23:16]
    logic        m_axis_tlast;   // frame_end_out

    t_mode  current_mode;
    t_pixel expected_pixels[$];
    int     mismatches;
    bit     bursty;
    int     sink_hold;

    rgb_ycbcr_color_converter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [7:0] round_sat(input longint acc);
        longint v;
        v = acc + (longint'(1) << (FB - 1));
        if (v < 0) return 8'd0;
        v = v >>> FB;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic t_pixel convert_pixel(input t_mode mode, input logic [7:0] a,
                                             input logic [7:0] b, input logic [7:0] c,
                                             input logic eof);
        t_pixel p;
        longint la, lb, lc, cb, cr, yv;
        la = longint'(a);
        lb = longint'(b);
        lc = longint'(c);
        p.eof = eof;
        case (mode)
            MODE_BGR2YCC: begin
                p.a = round_sat(CF_YR * lc + CF_YG * lb + CF_YB * la);
                p.b = round_sat(CHROMA - CF_CB_R * lc - CF_CB_G * lb + CF_HALF * la);
                p.c = round_sat(CHROMA + CF_HALF * lc - CF_CR_G * lb - CF_CR_B * la);
            end
            MODE_YCC2BGR: begin
                yv  = la << FB;
                cb  = lb - 128;
                cr  = lc - 128;
                p.a = round_sat(yv + CF_B_CB * cb);
                p.b = round_sat(yv - CF_G_CB * cb - CF_G_CR * cr);
                p.c = round_sat(yv + CF_R_CR * cr);
            end
            MODE_BGR2GRAY: begin
                p.a = round_sat(CF_YR * lc + CF_YG * lb + CF_YB * la);
                p.b = p.a;
                p.c = p.a;
            end
            default: begin
                p.a = a;
                p.b = b;
                p.c = c;
            end
        endcase
        return p;
    endfunction

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic push_pixel(input logic [7:0] a, input logic [7:0] b,
                              input logic [7:0] c, input logic eof);
        while (bursty && $urandom_range(99) < 20) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 24'($urandom);
            s_axis_tlast  <= 1'($urandom);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c, b, a};
        s_axis_tlast  <= eof;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_pixels.push_back(convert_pixel(current_mode, a, b, c, eof));
        @(negedge i_clk);
    endtask

    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH) @(negedge i_clk);
    endtask

    task automatic load_mode(input t_mode mode);
        quiesce();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 2'($urandom);
        current_mode = mode;
    endtask

    task automatic push_random(input int count);
        repeat (count) begin
            push_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                       $urandom_range(7) == 0);
        end
    endtask

    task automatic test_forward_extremes();
        push_pixel(8'd0,   8'd0,   8'd0,   1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        push_pixel(8'd255, 8'd0,   8'd0,   1'b0);
        push_pixel(8'd0,   8'd255, 8'd0,   1'b1);
        push_pixel(8'd0,   8'd0,   8'd255, 1'b0);
        push_pixel(8'd255, 8'd0,   8'd255, 1'b0);
    endtask

    task automatic test_inverse_clamp();
        load_mode(MODE_YCC2BGR);
        push_pixel(8'd0,   8'd0,   8'd0,   1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        push_pixel(8'd128, 8'd128, 8'd128, 1'b0);
        push_pixel(8'd0,   8'd255, 8'd0,   1'b0);
        push_pixel(8'd255, 8'd0,   8'd255, 1'b1);
        push_pixel(8'd16,  8'd0,   8'd255, 1'b0);
    endtask

    task automatic test_gray();
        load_mode(MODE_BGR2GRAY);
        push_pixel(8'd0,   8'd0,   8'd0,   1'b0);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        push_pixel(8'd0,   8'd0,   8'd255, 1'b0);
        push_pixel(8'd37,  8'd201, 8'd90,  1'b0);
    endtask

    task automatic test_bypass();
        load_mode(MODE_BYPASS);
        push_pixel(8'd0,   8'd0,   8'd0,   1'b1);
        push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        push_pixel(8'd170, 8'd85,  8'd15,  1'b1);
    endtask

    task automatic test_random_modes();
        t_mode order[6];
        order = '{MODE_BGR2GRAY, MODE_BGR2YCC, MODE_YCC2BGR,
                  MODE_BYPASS, MODE_YCC2BGR, MODE_BGR2YCC};
        foreach (order[i]) begin
            load_mode(order[i]);
            // hold a steady stream on both sides for part of the second pass
            if (i == 1) begin
                push_random(40);
                bursty = 1'b0;
                push_random(130);
                bursty = 1'b1;
            end else begin
                push_random(170);
            end
        end
    endtask

    task automatic test_backpressure();
        load_mode(MODE_BGR2YCC);
        bursty    = 1'b0;
        sink_hold = 80;
        push_random(60);
        quiesce();
        bursty = 1'b1;
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                m_axis_tready <= 1'b0;
                sink_hold--;
            end else begin
                m_axis_tready <= !bursty || ($urandom_range(99) >= 20);
            end
        end
    end

    always @(posedge i_clk) begin : check_output
        t_pixel want;
        t_pixel got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16], m_axis_tlast};
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: a=%0d b=%0d c=%0d last=%b",
                             got.a, got.b, got.c, got.eof);
            end else begin
                want = expected_pixels.pop_front();
                if (got.a !== want.a || got.b !== want.b || got.c !== want.c ||
                    got.eof !== want.eof) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected a=%0d b=%0d c=%0d last=%b, got a=%0d b=%0d c=%0d last=%b",
                                 want.a, want.b, want.c, want.eof,
                                 got.a, got.b, got.c, got.eof);
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 2'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 24'd0;
        s_axis_tlast  = 1'b0;
        current_mode  = MODE_BGR2YCC;
        mismatches    = 0;
        bursty        = 1'b1;
        sink_hold     = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_forward_extremes();
        test_inverse_clamp();
        test_gray();
        test_bypass();
        test_random_modes();
        test_backpressure();
        quiesce();

        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: rgb_ycbcr_color_converter.f
hw/rtl/rgbycc_pkg.sv
hw/rtl/rgbycc_lane.sv
hw/rtl/rgb_ycbcr_color_converter.sv
tb/sv/rgb_ycbcr_color_converter_tb.sv
